// ----- rtl/brb_pkg.sv -----
package brb_pkg;

    // Ring storage and pointer widths.
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SIZE_W = ADDR_W + 1;

    // Burst reads are cut at this many bytes.
    localparam int MAX_BURST = 64;
    localparam int BLEN_W    = 7;
    localparam int REM_W     = $clog2(MAX_BURST + 1);

    // Stream payload widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    typedef logic [S_TUSER_W-1:0] action_t;

    localparam action_t ACT_PUT   = 3'd0;
    localparam action_t ACT_GET   = 3'd1;
    localparam action_t ACT_TAKE  = 3'd2;
    localparam action_t ACT_BURST = 3'd3;
    localparam action_t ACT_CLEAR = 3'd4;

    typedef struct packed {
        logic [SIZE_W-1:0] count;
        logic              full;
        logic              empty;
    } ring_stat_t;

endpackage

// ----- rtl/brb_ram.sv -----
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered and holds until the next read.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/byte_ring_buffer_with_loss_flag.sv -----
// Byte ring buffer with one slot kept empty and a sticky loss flag.
//
// Each item on the s_ channel carries one action in s_tuser (put, get, take,
// burst read, clear) with its byte and burst length in s_tdata. Every item
// produces one or more items on the m_ channel; each carries the popped byte,
// its valid flag in m_tuser, and the buffer status after that pop. m_tlast
// marks the final item caused by an input item.
// Put, clear and refused pops answer in the cycle after acceptance, and while the
// receiver keeps up the block takes a new item every cycle for them. A pop goes
// through the byte memory, whose read data is registered, and then through the
// output register; a burst of n bytes then streams one byte per cycle while the
// receiver keeps up; no new item is taken until the last byte is loaded.
// The configuration write sets the number of ring slots in use and empties
// the ring. Reset empties the ring, clears the loss flag and selects all
// slots; the byte memory itself is not cleared and needs no clearing pass.
// When the receiver stalls, the output register holds its item and the block
// stops popping; a burst resumes where it stopped, no byte is lost.
module byte_ring_buffer_with_loss_flag (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: slots in use.
    input  logic                            cfg_we,
    input  logic [brb_pkg::SIZE_W-1:0]      cfg_wdata,
    // Input items.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [brb_pkg::S_TDATA_W-1:0]   s_tdata,  // data_in[7:0], burst_len[14:8]
    input  logic [brb_pkg::S_TUSER_W-1:0]   s_tuser,  // action[2:0]
    // Result items.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [brb_pkg::M_TDATA_W-1:0]   m_tdata,  // data_out[7:0], stored_count[16:8],
                                                      // is_full[17], is_empty[18],
                                                      // loss_seen[19]
    output logic [brb_pkg::M_TUSER_W-1:0]   m_tuser,  // data_valid[0]
    output logic                            m_tlast
);

    import brb_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_POP  = 1'b1;

    // Control state.
    logic               state_reg,  state_next;
    logic [ADDR_W-1:0]  head_reg,   head_next;
    logic [ADDR_W-1:0]  tail_reg,   tail_next;
    logic               loss_reg,   loss_next;
    logic [SIZE_W-1:0]  size_reg,   size_next;
    logic [REM_W-1:0]   rem_reg,    rem_next;
    logic               m_valid_reg, m_valid_next;

    // Output payload.
    logic [7:0]         dout_reg;
    logic               dvalid_reg;
    ring_stat_t         stat_reg;
    logic               oloss_reg;
    logic               last_reg;

    // Input fields.
    action_t            act;
    logic [7:0]         din;
    logic [BLEN_W-1:0]  blen;
    logic [BLEN_W-1:0]  blen_sat;

    logic               out_free;
    logic               accept;
    logic               empty_now;
    logic               full_now;
    logic               pop_start;
    logic               fin;
    logic               emit;

    // Output load.
    logic               ld;
    logic [ADDR_W-1:0]  ld_head;
    logic [ADDR_W-1:0]  ld_tail;
    logic               ld_loss;
    logic [7:0]         ld_data;
    logic               ld_dvalid;
    logic               ld_last;
    ring_stat_t         ld_stat;

    // Memory ports.
    logic               ram_we;
    logic               ram_re;
    logic [7:0]         ram_rdata;

    // Next pointer position, wrapping at the number of slots in use.
    function automatic logic [ADDR_W-1:0] wrap_next(
        input logic [ADDR_W-1:0] p,
        input logic [SIZE_W-1:0] size
    );
        logic [SIZE_W-1:0] p1;
        p1 = {1'b0, p} + SIZE_W'(1);
        return (p1 == size) ? '0 : p1[ADDR_W-1:0];
    endfunction

    function automatic ring_stat_t ring_stat(
        input logic [ADDR_W-1:0] head,
        input logic [ADDR_W-1:0] tail,
        input logic [SIZE_W-1:0] size
    );
        ring_stat_t st;
        if (head == tail) begin
            st.count = '0;
        end else if (head > tail) begin
            st.count = {1'b0, head} - {1'b0, tail};
        end else begin
            st.count = size - ({1'b0, tail} - {1'b0, head});
        end
        st.full  = (wrap_next(head, size) == tail);
        st.empty = (head == tail);
        return st;
    endfunction

    assign act  = s_tuser;
    assign din  = s_tdata[7:0];
    assign blen = s_tdata[14:8];
    assign blen_sat = (blen > BLEN_W'(MAX_BURST)) ? BLEN_W'(MAX_BURST) : blen;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign empty_now = (head_reg == tail_reg);
    assign full_now  = (wrap_next(head_reg, size_reg) == tail_reg);

    // A pop that goes to memory; refused pops answer at once.
    always_comb begin
        case (act)
            ACT_GET:   pop_start = !empty_now && !loss_reg;
            ACT_TAKE:  pop_start = !empty_now;
            ACT_BURST: pop_start = !empty_now && (blen_sat != '0);
            default:   pop_start = 1'b0;
        endcase
    end

    // During a pop the tail has already moved past the byte being shown, so
    // the status reflects the ring after this pop.
    assign emit = (state_reg == ST_POP) && out_free;
    assign fin  = (rem_reg == '0) || empty_now;

    // Writes land on a put to a ring that is not full; reads start on a pop and on each further burst byte.
    assign ram_we = accept && (act == ACT_PUT) && !full_now;
    assign ram_re = (accept && pop_start) || (emit && !fin);

    brb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata (din),
        .re    (ram_re),
        .raddr (tail_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        loss_next  = loss_reg;
        size_next  = size_reg;
        rem_next   = rem_reg;

        ld        = 1'b0;
        ld_head   = head_reg;
        ld_tail   = tail_reg;
        ld_loss   = loss_reg;
        ld_data   = '0;
        ld_dvalid = 1'b0;
        ld_last   = 1'b1;

        if (cfg_we) begin
            // Out-of-range sizes are clamped to one slot or the full store.
            if (cfg_wdata == '0) begin
                size_next = SIZE_W'(1);
            end else if (cfg_wdata > SIZE_W'(DEPTH)) begin
                size_next = SIZE_W'(DEPTH);
            end else begin
                size_next = cfg_wdata;
            end
            head_next = '0;
            tail_next = '0;
            loss_next = 1'b0;
        end else if (accept) begin
            case (act)
                ACT_PUT: begin
                    ld_head = full_now ? head_reg : wrap_next(head_reg, size_reg);
                    // Head meeting tail after a put only happens with one slot.
                    if (ld_head == tail_reg) begin
                        ld_tail = wrap_next(tail_reg, size_reg);
                        ld_loss = 1'b1;
                    end
                    ld        = 1'b1;
                    head_next = ld_head;
                    tail_next = ld_tail;
                    loss_next = ld_loss;
                end
                ACT_GET, ACT_TAKE, ACT_BURST: begin
                    if (pop_start) begin
                        tail_next  = wrap_next(tail_reg, size_reg);
                        state_next = ST_POP;
                        rem_next   = (act == ACT_BURST) ? REM_W'(blen_sat - BLEN_W'(1)) : '0;
                    end else begin
                        ld = 1'b1;
                    end
                end
                ACT_CLEAR: begin
                    ld        = 1'b1;
                    ld_head   = '0;
                    ld_tail   = '0;
                    ld_loss   = 1'b0;
                    head_next = '0;
                    tail_next = '0;
                    loss_next = 1'b0;
                end
                default: begin
                    ld = 1'b1;
                end
            endcase
        end else if (emit) begin
            ld        = 1'b1;
            ld_data   = ram_rdata;
            ld_dvalid = 1'b1;
            ld_last   = fin;
            if (fin) begin
                state_next = ST_IDLE;
                rem_next   = '0;
            end else begin
                tail_next = wrap_next(tail_reg, size_reg);
                rem_next  = rem_reg - REM_W'(1);
            end
        end

        ld_stat = ring_stat(ld_head, ld_tail, size_reg);

        if (ld) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            loss_reg    <= 1'b0;
            size_reg    <= SIZE_W'(DEPTH);
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            loss_reg    <= loss_next;
            size_reg    <= size_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            dout_reg   <= ld_data;
            dvalid_reg <= ld_dvalid;
            stat_reg   <= ld_stat;
            oloss_reg  <= ld_loss;
            last_reg   <= ld_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, oloss_reg, stat_reg.empty, stat_reg.full,
                       stat_reg.count, dout_reg};
    assign m_tuser  = dvalid_reg;
    assign m_tlast  = last_reg;

    // Both pointers always stay inside the slots in use.
    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg < size_reg) && (tail_reg < size_reg))
        else $error("ring pointer outside the slots in use");

    // The loss flag can only be raised with a single slot in use.
    a_loss_size: assert property (@(posedge aclk) disable iff (!aresetn)
        loss_reg |-> (size_reg == SIZE_W'(1)))
        else $error("loss flag set with more than one slot");

    // No burst bytes are left pending once the block is idle.
    a_rem_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (rem_reg == '0))
        else $error("burst count left over in idle");

    // An item without a popped byte shows zero data.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !dvalid_reg) |-> (dout_reg == '0))
        else $error("data shown without a popped byte");

endmodule

// ----- test/tb_byte_ring_buffer_with_loss_flag.sv -----
`timescale 1ns / 1ps

module tb_byte_ring_buffer_with_loss_flag;

    import brb_pkg::*;

    // Action codes above clear are not used by the block and must be ignored.
    localparam action_t ACT_UNKNOWN_LO = ACT_CLEAR + 3'd1;
    localparam action_t ACT_UNKNOWN_HI = 3'd7;

    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic [7:0]        data_out;
        logic              valid;
        logic [SIZE_W-1:0] count;
        logic              full;
        logic              empty;
        logic              loss;
        logic              last;
    } reply_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        action_t           act;
        logic [7:0]        data;
        logic [BLEN_W-1:0] blen;
        logic [SIZE_W-1:0] slots;
        bit                fixed;
        reply_t            reply;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [SIZE_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    byte_ring_buffer_with_loss_flag uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Shadow copy of the ring, kept in step with every accepted item.
    logic [7:0]  shadow_mem [DEPTH];
    int unsigned shadow_head;
    int unsigned shadow_tail;
    int unsigned shadow_slots;
    bit          shadow_loss;

    reply_t ring_replies[$];
    int     fail_count    = 0;
    int     hold_requests = 0;
    int     burst_left    = 0;
    row_t   plan[$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int unsigned wrap_inc(int unsigned p);
        return (p + 1) % shadow_slots;
    endfunction

    function automatic void push_reply(logic [7:0] d, bit v, bit fin);
        reply_t      r;
        int unsigned cnt;
        if (shadow_head == shadow_tail) begin
            cnt = 0;
        end else if (shadow_head > shadow_tail) begin
            cnt = shadow_head - shadow_tail;
        end else begin
            cnt = shadow_slots - (shadow_tail - shadow_head);
        end
        r.data_out = d;
        r.valid    = v;
        r.count    = cnt[SIZE_W-1:0];
        r.full     = (wrap_inc(shadow_head) == shadow_tail);
        r.empty    = (shadow_head == shadow_tail);
        r.loss     = shadow_loss;
        r.last     = fin;
        ring_replies.push_back(r);
    endfunction

    function automatic void clear_shadow();
        shadow_head = 0;
        shadow_tail = 0;
        shadow_loss = 1'b0;
    endfunction

    // Applies one action to the shadow ring and queues the replies it causes.
    function automatic void compute_ring_replies(action_t act, logic [7:0] d,
                                                 logic [BLEN_W-1:0] bl);
        int unsigned n;
        int unsigned k;
        logic [7:0]  b;
        case (act)
            ACT_PUT: begin
                if (wrap_inc(shadow_head) != shadow_tail) begin
                    shadow_mem[shadow_head] = d;
                    shadow_head = wrap_inc(shadow_head);
                end
                // Only possible with a single slot: the tail is pushed along.
                if (shadow_head == shadow_tail) begin
                    shadow_tail = wrap_inc(shadow_tail);
                    shadow_loss = 1'b1;
                end
                push_reply(8'h00, 1'b0, 1'b1);
            end
            ACT_GET, ACT_TAKE: begin
                if (shadow_head != shadow_tail && (act == ACT_TAKE || !shadow_loss)) begin
                    b = shadow_mem[shadow_tail];
                    shadow_tail = wrap_inc(shadow_tail);
                    push_reply(b, 1'b1, 1'b1);
                end else begin
                    push_reply(8'h00, 1'b0, 1'b1);
                end
            end
            ACT_BURST: begin
                n = (bl > MAX_BURST) ? MAX_BURST : bl;
                k = 0;
                while (k < n && shadow_head != shadow_tail) begin
                    b = shadow_mem[shadow_tail];
                    shadow_tail = wrap_inc(shadow_tail);
                    k++;
                    push_reply(b, 1'b1, (k == n) || (shadow_head == shadow_tail));
                end
                if (k == 0) begin
                    push_reply(8'h00, 1'b0, 1'b1);
                end
            end
            ACT_CLEAR: begin
                clear_shadow();
                push_reply(8'h00, 1'b0, 1'b1);
            end
            default: begin
                push_reply(8'h00, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic reply_t status_reply(int unsigned cnt, bit full, bit empty, bit loss);
        reply_t r;
        r.data_out = 8'h00;
        r.valid    = 1'b0;
        r.count    = cnt[SIZE_W-1:0];
        r.full     = full;
        r.empty    = empty;
        r.loss     = loss;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic row_t item_row(action_t act, logic [7:0] d, logic [BLEN_W-1:0] bl);
        row_t r;
        r.kind  = ROW_ITEM;
        r.act   = act;
        r.data  = d;
        r.blen  = bl;
        r.slots = '0;
        r.fixed = 1'b0;
        r.reply = status_reply(0, 1'b0, 1'b1, 1'b0);
        return r;
    endfunction

    function automatic row_t fixed_row(action_t act, logic [7:0] d, logic [BLEN_W-1:0] bl,
                                       reply_t rep);
        row_t r;
        r       = item_row(act, d, bl);
        r.fixed = 1'b1;
        r.reply = rep;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [SIZE_W-1:0] v);
        row_t r;
        r       = item_row(ACT_CLEAR, 8'h00, '0);
        r.kind  = ROW_CFG;
        r.slots = v;
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Lowers valid and waits until every queued reply has come back.
    task automatic drain_ring();
        s_tvalid <= 1'b0;
        while (ring_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_slots(logic [SIZE_W-1:0] v);
        int unsigned s;
        drain_ring();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        s = 32'(v);
        if (s < 1) s = 1;
        if (s > DEPTH) s = DEPTH;
        shadow_slots = s;
        clear_shadow();
    endtask

    // Offers one item, pacing the sender in bursts with gaps between them.
    task automatic send_item(action_t act, logic [7:0] d, logic [BLEN_W-1:0] bl,
                             bit fixed, reply_t rep);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 99) < 15) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 99) < 20) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {1'b0, bl, d};
        do @(posedge aclk); while (!s_tready);
        compute_ring_replies(act, d, bl);
        if (fixed) begin
            void'(ring_replies.pop_back());
            ring_replies.push_back(rep);
        end
    endtask

    // Receiver: random stall pattern whose stall rate is redrawn at regular intervals, plus long
    // hold-offs on request from the stimulus.
    initial begin : receiver
        int unsigned cyc;
        int unsigned pct;
        int          served;
        cyc      = 0;
        pct      = 0;
        served   = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (served < hold_requests) begin
                served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (cyc % 50 == 0) begin
                    case ($urandom_range(0, 4))
                        0, 1:    pct = 0;
                        2:       pct = 25;
                        3:       pct = 50;
                        default: pct = 85;
                    endcase
                end
                cyc++;
                m_tready <= ($urandom_range(0, 99) >= pct);
            end
        end
    end

    always @(posedge aclk) begin : monitor
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (ring_replies.size() == 0) begin
                $error("result item arrived with nothing expected");
                fail_count++;
            end else begin
                want = ring_replies.pop_front();
                check_field("data_out", want.data_out, m_tdata[7:0]);
                check_field("data_valid", want.valid, m_tuser[0]);
                check_field("stored_count", want.count, m_tdata[16:8]);
                check_field("is_full", want.full, m_tdata[17]);
                check_field("is_empty", want.empty, m_tdata[18]);
                check_field("loss_seen", want.loss, m_tdata[19]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    initial begin : stimulus
        int unsigned       p;
        int unsigned       i;
        int unsigned       r;
        int unsigned       put_pct;
        action_t           act;
        logic [SIZE_W-1:0] cfgv;
        logic [7:0]        d;
        logic [BLEN_W-1:0] bl;
        reply_t            none;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        none      = status_reply(0, 1'b0, 1'b1, 1'b0);

        for (i = 0; i < DEPTH; i++) shadow_mem[i] = 8'h00;
        shadow_slots = DEPTH;
        clear_shadow();

        // Empty after reset, then the extremes of every field.
        plan.push_back(fixed_row(ACT_GET, 8'hFF, 7'd1, none));
        plan.push_back(fixed_row(ACT_TAKE, 8'h00, 7'd1, none));
        plan.push_back(fixed_row(ACT_BURST, 8'h00, 7'd5, none));
        plan.push_back(fixed_row(ACT_BURST, 8'h00, 7'd0, none));
        plan.push_back(fixed_row(ACT_UNKNOWN_LO, 8'hFF, 7'd127, none));
        plan.push_back(fixed_row(ACT_UNKNOWN_HI, 8'h00, 7'd0, none));
        plan.push_back(fixed_row(ACT_PUT, 8'hFF, 7'd0, status_reply(1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(fixed_row(ACT_PUT, 8'h00, 7'd127, status_reply(2, 1'b0, 1'b0, 1'b0)));
        plan.push_back(item_row(ACT_PUT, 8'hA5, 7'd3));
        plan.push_back(item_row(ACT_GET, 8'h00, 7'd0));
        // A burst longer than the limit stops once the ring runs dry.
        plan.push_back(item_row(ACT_BURST, 8'h00, 7'd127));
        // Two slots hold one byte; a second put is refused.
        plan.push_back(cfg_row(9'd2));
        plan.push_back(fixed_row(ACT_PUT, 8'h5A, 7'd0, status_reply(1, 1'b1, 1'b0, 1'b0)));
        plan.push_back(fixed_row(ACT_PUT, 8'h33, 7'd0, status_reply(1, 1'b1, 1'b0, 1'b0)));
        plan.push_back(item_row(ACT_TAKE, 8'h00, 7'd0));
        // A size of zero acts as one slot: every put is lost and sets the flag.
        plan.push_back(cfg_row(9'd0));
        plan.push_back(fixed_row(ACT_PUT, 8'h81, 7'd0, status_reply(0, 1'b1, 1'b1, 1'b1)));
        plan.push_back(fixed_row(ACT_GET, 8'h00, 7'd0, status_reply(0, 1'b1, 1'b1, 1'b1)));
        plan.push_back(fixed_row(ACT_TAKE, 8'h00, 7'd0, status_reply(0, 1'b1, 1'b1, 1'b1)));
        plan.push_back(fixed_row(ACT_BURST, 8'h00, 7'd64, status_reply(0, 1'b1, 1'b1, 1'b1)));
        plan.push_back(fixed_row(ACT_CLEAR, 8'h00, 7'd0, status_reply(0, 1'b1, 1'b1, 1'b0)));
        plan.push_back(cfg_row(9'd3));
        plan.push_back(item_row(ACT_PUT, 8'h12, 7'd0));
        plan.push_back(item_row(ACT_PUT, 8'h34, 7'd0));
        plan.push_back(item_row(ACT_BURST, 8'h00, 7'd64));
        // Above the depth the size saturates at the full ring.
        plan.push_back(cfg_row(9'd511));
        plan.push_back(item_row(ACT_PUT, 8'h7E, 7'd0));
        plan.push_back(fixed_row(ACT_CLEAR, 8'h00, 7'd0, none));
        plan.push_back(fixed_row(ACT_BURST, 8'h00, 7'd64, none));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CFG) begin
                write_slots(plan[k].slots);
            end else begin
                send_item(plan[k].act, plan[k].data, plan[k].blen, plan[k].fixed,
                          plan[k].reply);
            end
        end

        for (p = 0; p < 10; p++) begin
            case (p)
                0:       cfgv = 9'd2;
                1:       cfgv = 9'd0;
                2:       cfgv = 9'd5;
                3:       cfgv = 9'd3;
                4:       cfgv = 9'd511;
                5:       cfgv = SIZE_W'($urandom_range(6, 20));
                6:       cfgv = 9'd1;
                7:       cfgv = SIZE_W'($urandom_range(257, 511));
                8:       cfgv = 9'd256;
                default: cfgv = SIZE_W'($urandom_range(2, 40));
            endcase
            write_slots(cfgv);
            // Large rings need many more puts before they get anywhere near full.
            put_pct = (shadow_slots >= 64) ? 70 : 45;
            for (i = 0; i < 41; i++) begin
                if ((p == 4 && i == 3) || (p == 9 && i == 10)) begin
                    hold_requests <= hold_requests + 1;
                end
                if (p == 5 && i == 20) begin
                    drain_ring();
                end
                if ($urandom_range(0, 99) < put_pct) begin
                    act = ACT_PUT;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 25) act = ACT_GET;
                    else if (r < 50) act = ACT_TAKE;
                    else if (r < 80) act = ACT_BURST;
                    else if (r < 90) act = ACT_CLEAR;
                    else act = action_t'($urandom_range(ACT_UNKNOWN_LO, ACT_UNKNOWN_HI));
                end
                d = 8'($urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (r < 70) bl = BLEN_W'($urandom_range(1, 8));
                else if (r < 90) bl = BLEN_W'($urandom_range(1, MAX_BURST));
                else bl = BLEN_W'($urandom_range(0, 127));
                send_item(act, d, bl, 1'b0, none);
            end
        end

        drain_ring();
        repeat (16) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
